// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the nearest-point search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/nps3d_pkg.sv =====
// Shared constants of the nearest-point search block.
package nps3d_pkg;

  localparam int COUNT_W = 11;
  localparam int DIST_W = 35;
  localparam int IDX_W = 10;
  localparam int PORT_COORD_W = 16;
  localparam int CFG_DATA_W = 35;
  localparam int CFG_INDEX_W = 1;

  localparam logic [DIST_W-1:0] DEFAULT_LIMIT = DIST_W'(9999999);
  localparam logic [COUNT_W-1:0] DEFAULT_COUNT = COUNT_W'(1);

  localparam logic [CFG_INDEX_W-1:0] REG_REF_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_LIMIT = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// ===== src/nearest_point_3d_search.sv =====
// Brute-force 3D nearest-point search over a table of reference points.
// A load never raises busy. A query over n = min(ref_count, MAX_REFS) points keeps busy
// high while the scan issues them and the distance pipeline drains, then raises done for one
// cycle with the result; busy goes high for a query even when n is 0.
// One distance pipeline takes one point per cycle, and the receiver cannot stall it.
// Synchronous reset sets ref_count to 1 and distance_limit to 9999999; the table is not cleared.
`include "assert_macros.svh"

module nearest_point_3d_search #(
  parameter int MAX_REFS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  output logic                                      busy,
  input  logic                                      opcode,
  input  logic [nps3d_pkg::IDX_W-1:0]               ref_slot,
  input  logic signed [nps3d_pkg::PORT_COORD_W-1:0] coord_x,
  input  logic signed [nps3d_pkg::PORT_COORD_W-1:0] coord_y,
  input  logic signed [nps3d_pkg::PORT_COORD_W-1:0] coord_z,
  input  logic                                      last_query,
  input  logic                                      cfg_write_en,
  input  logic [nps3d_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [nps3d_pkg::CFG_DATA_W-1:0]          cfg_data,
  output logic                                      done,
  output logic [nps3d_pkg::IDX_W-1:0]               nearest_index,
  output logic [nps3d_pkg::DIST_W-1:0]              squared_distance,
  output logic                                      batch_end
);

  localparam int CB = COORD_BITS;
  localparam int EXT_W = (COORD_BITS > nps3d_pkg::PORT_COORD_W) ?
                         COORD_BITS : nps3d_pkg::PORT_COORD_W;
  localparam int AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int CW = $clog2(MAX_REFS + 1);
  localparam int SQ_W = 2 * CB;
  localparam int SUM_W = SQ_W + 2;
  localparam int CMP_W = (SUM_W > nps3d_pkg::DIST_W) ? SUM_W : nps3d_pkg::DIST_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  typedef logic [2:0][CB-1:0] point_t;

  // Configuration registers.
  logic [nps3d_pkg::COUNT_W-1:0] ref_count;
  logic [nps3d_pkg::DIST_W-1:0]  distance_limit;

  // Sequencer.
  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] issue_left;
  logic [CW-1:0] count_sat;

  // Reference table.
  point_t mem [MAX_REFS];
  point_t rd_data;
  point_t in_point;
  point_t query;
  logic   query_last;

  // Distance pipeline.
  logic                 v1, v2, v3, v4;
  logic [AW-1:0]        idx1, idx2, idx3, idx4;
  logic [2:0][CB-1:0]   mag2;
  logic [2:0][CB-1:0]   mag_next;
  logic [2:0][SQ_W-1:0] sq3;
  logic [SUM_W-1:0]     sum4;

  logic [nps3d_pkg::DIST_W-1:0] best;
  logic [AW-1:0]                best_idx;

  logic accept;
  logic accept_query;
  logic accept_load;
  logic issue;
  logic pipe_busy;

  assign accept = start && !busy;
  assign accept_query = accept && (opcode == nps3d_pkg::OP_QUERY);
  assign accept_load = accept && (opcode == nps3d_pkg::OP_LOAD) &&
                       (32'(ref_slot) < 32'(MAX_REFS));
  assign issue = (state == ST_SCAN) && (issue_left != '0);
  assign pipe_busy = v1 || v2 || v3 || v4;

  assign in_point[0] = CB'(EXT_W'(coord_x));
  assign in_point[1] = CB'(EXT_W'(coord_y));
  assign in_point[2] = CB'(EXT_W'(coord_z));

  assign count_sat = (32'(ref_count) > 32'(MAX_REFS)) ? CW'(MAX_REFS) : CW'(ref_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= nps3d_pkg::DEFAULT_COUNT;
      distance_limit <= nps3d_pkg::DEFAULT_LIMIT;
    end else if (cfg_write_en) begin
      if (cfg_index == nps3d_pkg::REG_REF_COUNT) begin
        ref_count <= cfg_data[nps3d_pkg::COUNT_W-1:0];
      end else if (cfg_index == nps3d_pkg::REG_DISTANCE_LIMIT) begin
        distance_limit <= cfg_data[nps3d_pkg::DIST_W-1:0];
      end
    end
  end

  // One write port for loads, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (accept_load) begin
      mem[AW'(ref_slot)] <= in_point;
    end
    if (issue) begin
      rd_data <= mem[AW'(issue_left - CW'(1))];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_query) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue_left == '0 && !pipe_busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = accept_query ? ST_SCAN : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      issue_left <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      state <= state_next;
      if (accept_query) begin
        issue_left <= count_sat;
      end else if (issue) begin
        issue_left <= issue_left - CW'(1);
      end
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Absolute coordinate differences; each fits in CB unsigned bits.
  always_comb begin
    logic signed [CB:0] diff;
    for (int k = 0; k < 3; k++) begin
      diff = $signed({rd_data[k][CB-1], rd_data[k]}) - $signed({query[k][CB-1], query[k]});
      mag_next[k] = diff[CB] ? CB'(-diff) : CB'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (accept_query) begin
      query <= in_point;
      query_last <= last_query;
    end
    if (issue) idx1 <= AW'(issue_left - CW'(1));
    idx2 <= idx1;
    idx3 <= idx2;
    idx4 <= idx3;
    mag2 <= mag_next;
    for (int k = 0; k < 3; k++) begin
      sq3[k] <= SQ_W'(mag2[k]) * SQ_W'(mag2[k]);
    end
    sum4 <= SUM_W'(sq3[0]) + SUM_W'(sq3[1]) + SUM_W'(sq3[2]);
  end

  // The scan runs downward and only a strictly smaller distance wins, so a
  // tie keeps the higher index.
  always_ff @(posedge clk) begin
    if (accept_query) begin
      best <= distance_limit;
      best_idx <= '0;
    end else if (v4 && (CMP_W'(sum4) < CMP_W'(best))) begin
      best <= nps3d_pkg::DIST_W'(sum4);
      best_idx <= idx4;
    end
  end

  assign busy = (state == ST_SCAN);
  assign done = (state == ST_DONE);
  assign nearest_index = nps3d_pkg::IDX_W'(best_idx);
  assign squared_distance = best;
  assign batch_end = query_last;

  `ASSERT_NEXT(a_query_starts_scan, clk, rst, accept_query, busy, "query did not start a scan")
  `ASSERT_SAME(a_pipe_empty_when_idle, clk, rst, !busy, !pipe_busy, "pipeline active when idle")
  `ASSERT_NEXT(a_done_single_pulse, clk, rst, done, !done, "done held over one cycle")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the 3D nearest-point search block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 1024;
  // Slots loaded before the random traffic; every search stays inside them.
  localparam int FILLED_SLOTS = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [nps3d_pkg::DIST_W-1:0] LIMIT_MAX = '1;
  // Squared distance between two opposite corners of the coordinate cube.
  localparam longint unsigned CORNER_SPAN = 64'd12884508675;

  typedef logic signed [nps3d_pkg::PORT_COORD_W-1:0] coord_t;
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;
  typedef struct {
    logic [nps3d_pkg::IDX_W-1:0]  index;
    logic [nps3d_pkg::DIST_W-1:0] distance;
    logic                         last;
  } nearest_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              opcode = nps3d_pkg::OP_LOAD;
  logic [nps3d_pkg::IDX_W-1:0]       ref_slot = '0;
  coord_t                            coord_x = '0;
  coord_t                            coord_y = '0;
  coord_t                            coord_z = '0;
  logic                              last_query = 1'b0;
  logic                              cfg_write_en = 1'b0;
  logic [nps3d_pkg::CFG_INDEX_W-1:0] cfg_index = nps3d_pkg::REG_REF_COUNT;
  logic [nps3d_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                              done;
  logic [nps3d_pkg::IDX_W-1:0]       nearest_index;
  logic [nps3d_pkg::DIST_W-1:0]      squared_distance;
  logic                              batch_end;

  nearest_point_3d_search #(
    .MAX_REFS(TABLE_DEPTH),
    .COORD_BITS(nps3d_pkg::PORT_COORD_W)
  ) uut (.*);

  // Shadow copy of the block's table and registers.
  point_t                          point_table [TABLE_DEPTH];
  logic [nps3d_pkg::COUNT_W-1:0]   search_count = nps3d_pkg::DEFAULT_COUNT;
  logic [nps3d_pkg::DIST_W-1:0]    search_limit = nps3d_pkg::DEFAULT_LIMIT;
  nearest_t                        pending_nearest [$];
  int                              error_count = 0;
  int                              idle_pct = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int searched_slots();
    return (search_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(search_count);
  endfunction

  function automatic longint unsigned squared_gap(point_t a, point_t b);
    longint dx, dy, dz;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Downward scan with a strict compare, so the highest index wins a tie.
  function automatic nearest_t find_nearest(point_t q, logic last);
    nearest_t r;
    longint unsigned d;
    r.index = '0;
    r.distance = search_limit;
    r.last = last;
    for (int i = searched_slots() - 1; i >= 0; i--) begin
      d = squared_gap(point_table[i], q);
      if (d < r.distance) begin
        r.distance = nps3d_pkg::DIST_W'(d);
        r.index = nps3d_pkg::IDX_W'(i);
      end
    end
    return r;
  endfunction

  function automatic point_t make_point(int x, int y, int z);
    point_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    p.z = coord_t'(z);
    return p;
  endfunction

  function automatic point_t random_point();
    return make_point($urandom, $urandom, $urandom);
  endfunction

  function automatic point_t near_point(point_t c, int spread);
    return make_point(int'(c.x) + int'($urandom_range(2 * spread)) - spread,
                      int'(c.y) + int'($urandom_range(2 * spread)) - spread,
                      int'(c.z) + int'($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic logic [nps3d_pkg::DIST_W-1:0] random_limit();
    case ($urandom_range(4))
      0: return nps3d_pkg::DEFAULT_LIMIT;
      1: return LIMIT_MAX;
      2: return '0;
      3: return nps3d_pkg::DIST_W'({$urandom, $urandom});
      default: return nps3d_pkg::DIST_W'($urandom_range(1, 50_000_000));
    endcase
  endfunction

  function automatic int pick_spread();
    case ($urandom_range(3))
      0: return 0;
      1: return 16;
      2: return 1000;
      default: return 32767;
    endcase
  endfunction

  // One transfer on the command port; start stays high if the next item follows at once.
  task automatic send_item(logic op, logic [nps3d_pkg::IDX_W-1:0] slot, point_t p,
                           logic last);
    int gap;
    gap = 0;
    if (idle_pct > 0) begin
      while ($urandom_range(99) < idle_pct) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    ref_slot <= slot;
    coord_x <= p.x;
    coord_y <= p.y;
    coord_z <= p.z;
    last_query <= last;
    do @(posedge clk); while (busy);
    if (op == nps3d_pkg::OP_LOAD) begin
      point_table[slot] = p;
    end else begin
      pending_nearest.push_back(find_nearest(p, last));
    end
  endtask

  task automatic load_point(int slot, point_t p);
    send_item(nps3d_pkg::OP_LOAD, nps3d_pkg::IDX_W'(slot), p, 1'($urandom));
  endtask

  task automatic query_point(point_t p, logic last);
    send_item(nps3d_pkg::OP_QUERY, nps3d_pkg::IDX_W'($urandom), p, last);
  endtask

  // Holds the sender off until every query has answered and the block is idle.
  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (pending_nearest.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [nps3d_pkg::CFG_INDEX_W-1:0] idx,
                           logic [nps3d_pkg::CFG_DATA_W-1:0] value);
    wait_quiet();
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == nps3d_pkg::REG_REF_COUNT) begin
      search_count = value[nps3d_pkg::COUNT_W-1:0];
    end else begin
      search_limit = value[nps3d_pkg::DIST_W-1:0];
    end
  endtask

  task automatic set_search(logic [nps3d_pkg::COUNT_W-1:0] count,
                            logic [nps3d_pkg::DIST_W-1:0] limit);
    write_reg(nps3d_pkg::REG_REF_COUNT, nps3d_pkg::CFG_DATA_W'(count));
    write_reg(nps3d_pkg::REG_DISTANCE_LIMIT, nps3d_pkg::CFG_DATA_W'(limit));
  endtask

  always @(posedge clk) begin : check_results
    nearest_t want;
    if (!rst && done) begin
      if (pending_nearest.size() == 0) begin
        $error("result with no query waiting: nearest_index %0d squared_distance %0d",
               nearest_index, squared_distance);
        error_count++;
      end else begin
        want = pending_nearest.pop_front();
        if (nearest_index !== want.index) begin
          $error("nearest_index: expected %0d, actual %0d", want.index, nearest_index);
          error_count++;
        end
        if (squared_distance !== want.distance) begin
          $error("squared_distance: expected %0d, actual %0d", want.distance,
                 squared_distance);
          error_count++;
        end
        if (batch_end !== want.last) begin
          $error("batch_end: expected %0b, actual %0b", want.last, batch_end);
          error_count++;
        end
      end
    end
  end

  // Registers are left at their reset values: one slot and the default limit.
  task automatic test_reset_defaults();
    load_point(0, make_point(0, 0, 0));
    query_point(make_point(0, 0, 0), 1'b0);
    query_point(make_point(3162, 0, 0), 1'b0);
    query_point(make_point(3163, 0, 0), 1'b0);
    query_point(make_point(-3162, 0, 0), 1'b1);
  endtask

  task automatic test_coordinate_extremes();
    set_search(4, LIMIT_MAX);
    load_point(0, make_point(-32768, -32768, -32768));
    load_point(1, make_point(32767, 32767, 32767));
    load_point(2, make_point(0, 0, 0));
    load_point(3, make_point(32767, -32768, 0));
    load_point(TABLE_DEPTH - 1, make_point(-1, -1, -1));
    query_point(make_point(32767, 32767, 32767), 1'b0);
    query_point(make_point(-32768, -32768, -32768), 1'b1);
    query_point(make_point(-32768, 32767, -1), 1'b0);
    // A distance equal to the limit is not accepted; with the limit one above it, it is.
    set_search(1, nps3d_pkg::DIST_W'(CORNER_SPAN));
    query_point(make_point(32767, 32767, 32767), 1'b1);
    write_reg(nps3d_pkg::REG_DISTANCE_LIMIT, nps3d_pkg::CFG_DATA_W'(CORNER_SPAN + 1));
    query_point(make_point(32767, 32767, 32767), 1'b1);
  endtask

  task automatic test_ties_and_empty_search();
    set_search(3, nps3d_pkg::DEFAULT_LIMIT);
    load_point(0, make_point(100, 200, 300));
    load_point(1, make_point(100, 200, 300));
    load_point(2, make_point(100, 200, 300));
    query_point(make_point(100, 200, 300), 1'b0);
    load_point(2, make_point(110, 200, 300));
    query_point(make_point(105, 200, 300), 1'b1);
    set_search(0, nps3d_pkg::DEFAULT_LIMIT);
    query_point(make_point(100, 200, 300), 1'b1);
    set_search(3, '0);
    query_point(make_point(100, 200, 300), 1'b0);
  endtask

  // Fills the low slots that every later search stays inside, then searches all of them.
  task automatic test_table_fill();
    idle_pct = 0;
    for (int s = 0; s < FILLED_SLOTS; s++) load_point(s, random_point());
    set_search(FILLED_SLOTS, LIMIT_MAX);
    query_point(point_table[FILLED_SLOTS - 1], 1'b0);
    query_point(near_point(point_table[0], 100), 1'b1);
  endtask

  task automatic test_random_traffic();
    int sent, quota, n, hi, loads, queries;
    logic [nps3d_pkg::COUNT_W-1:0] count;
    point_t p;
    logic broken;
    quota = 50;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 71;
        2: idle_pct = 0;
        default: idle_pct = 9;
      endcase
      if ($urandom_range(7) == 0) begin
        count = '0;
      end else begin
        count = nps3d_pkg::COUNT_W'($urandom_range(1, FILLED_SLOTS));
      end
      set_search(count, random_limit());
      n = searched_slots();
      hi = (n + 4 > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : n + 4;
      sent = 0;
      while (sent < quota) begin
        // A batch: loads, then queries marked on the last, or at random if broken.
        loads = $urandom_range(0, 3);
        queries = $urandom_range(1, 6);
        broken = ($urandom_range(9) == 0);
        repeat (loads) begin
          case ($urandom_range(2))
            0: p = point_table[$urandom_range(FILLED_SLOTS - 1)];
            1: p = near_point(point_table[$urandom_range(FILLED_SLOTS - 1)], 8);
            default: p = random_point();
          endcase
          load_point(($urandom_range(3) != 0) ? $urandom_range(hi) :
                     $urandom_range(TABLE_DEPTH - 1), p);
          sent++;
        end
        for (int q = 0; q < queries; q++) begin
          if (n > 0 && $urandom_range(3) != 0) begin
            p = near_point(point_table[$urandom_range(n - 1)], pick_spread());
          end else begin
            p = random_point();
          end
          query_point(p, broken ? 1'($urandom) : (q == queries - 1));
          sent++;
        end
        if ($urandom_range(15) == 0) wait_quiet();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_coordinate_extremes();
    test_ties_and_empty_search();
    test_table_fill();
    test_random_traffic();
    wait_quiet();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
